// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

    localparam int COLUMNS_DEF    = 80;
    localparam int ROWS_DEF       = 25;
    localparam int TAB_SPACES_DEF = 4;

    localparam logic [15:0] ATTR_RESET = 16'h0700;
    localparam logic [7:0]  SPACE_CHAR   = 8'd32;
    localparam logic [7:0]  NEWLINE_CHAR = 8'd10;
    localparam logic [7:0]  TAB_CHAR     = 8'd9;

    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic REG_ATTRIBUTE = 1'b0;

    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int CELL_W     = 16;
    localparam int INDEX_W    = 11;

endpackage

// ===== rtl/tcw_ram.sv =====
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/text_console_writer.sv =====
// An ordinary character is written in ST_PUT and its result is strobed from a register; a tab writes
// TAB_SPACES spaces in turn. A read within the screen passes through ST_RDWAIT, while a read beyond
// it or an unused mode answers zero from idle. A scroll walks the whole screen memory, one cell a cycle,
// and then passes ST_DRAIN; a clear walks it too, both through the single write port of the memory.
// After reset the block clears the memory to zero with busy high; the results are strobed for one
// cycle and the receiver cannot stall them.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS    = COLUMNS_DEF,
    parameter int ROWS       = ROWS_DEF,
    parameter int TAB_SPACES = TAB_SPACES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           mode,
    input  logic [7:0]           char_code,
    input  logic [INDEX_W-1:0]   cell_index,
    output logic                 done,
    output logic [ROW_OUT_W-1:0] cursor_row,
    output logic [COL_OUT_W-1:0] cursor_col,
    output logic [CELL_W-1:0]    cell_value,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS + 2);
    localparam int CNT_W  = $clog2(TAB_SPACES + 1);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_PUT    = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_CLEAR  = 3'd5;
    localparam logic [2:0] ST_RDWAIT = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [7:0]        code_reg, code_next;
    logic [15:0]       attr_reg;
    logic              done_reg, done_next;
    logic [15:0]       value_reg, value_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              pend_copy_reg, pend_copy_next;
    logic [ADDR_W-1:0] pend_addr_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [15:0]       mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_rdata;

    logic              wrap;
    logic [COL_W-1:0]  col_set;
    logic [ROW_W-1:0]  row_set;
    logic [ADDR_W-1:0] put_addr;
    logic [15:0]       fill;
    logic              scan_last;
    logic [ROW_W+ROW_OUT_W-1:0] row_wide;
    logic [COL_W+COL_OUT_W-1:0] col_wide;

    tcw_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_screen (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign fill      = attr_reg | {8'd0, SPACE_CHAR};
    assign scan_last = (32'(scan_reg) == CELLS - 1);
    assign wrap      = (32'(col_reg) >= COLUMNS);
    assign col_set   = wrap ? '0 : col_reg;
    assign row_set   = wrap ? row_reg + 1'b1 : row_reg;
    assign put_addr  = ADDR_W'(32'(row_set) * COLUMNS + 32'(col_set));

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        scan_next       = scan_reg;
        count_next      = count_reg;
        code_next       = code_reg;
        done_next       = 1'b0;
        value_next      = value_reg;
        pend_valid_next = 1'b0;
        pend_copy_next  = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = scan_reg;
        mem_wdata       = fill;
        mem_re          = 1'b0;
        mem_raddr       = ADDR_W'(cell_index);

        if (pend_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = pend_copy_reg ? mem_rdata : fill;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                scan_next = scan_reg + 1'b1;
                if (scan_last)
                begin
                    scan_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (mode)
                        MODE_PUT:
                        begin
                            code_next  = char_code;
                            count_next = (char_code == TAB_CHAR)
                                         ? CNT_W'(TAB_SPACES) : CNT_W'(1);
                            state_next = ST_PUT;
                        end
                        MODE_CLEAR:
                        begin
                            scan_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        MODE_READ:
                        begin
                            if (32'(cell_index) < CELLS)
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_RDWAIT;
                            end
                            else
                            begin
                                value_next = '0;
                                done_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            value_next = '0;
                            done_next  = 1'b1;
                        end
                    endcase
                end
            end
            ST_PUT:
            begin
                if (32'(row_set) >= ROWS)
                begin
                    col_next   = '0;
                    row_next   = ROW_W'(ROWS - 1);
                    scan_next  = '0;
                    state_next = ST_SCROLL;
                end
                else if (code_reg == NEWLINE_CHAR)
                begin
                    col_next   = '0;
                    row_next   = row_set + 1'b1;
                    value_next = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = put_addr;
                    mem_wdata  = attr_reg | ((code_reg == TAB_CHAR)
                                 ? {8'd0, SPACE_CHAR} : {8'd0, code_reg});
                    col_next   = col_set + 1'b1;
                    row_next   = row_set;
                    count_next = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1))
                    begin
                        value_next = '0;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCROLL:
            begin
                pend_valid_next = 1'b1;
                pend_copy_next  = (32'(scan_reg) < CELLS - COLUMNS);
                mem_re          = pend_copy_next;
                mem_raddr       = ADDR_W'(32'(scan_reg) + COLUMNS);
                scan_next       = scan_reg + 1'b1;
                if (scan_last)
                begin
                    scan_next  = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_PUT;
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                scan_next = scan_reg + 1'b1;
                if (scan_last)
                begin
                    scan_next  = '0;
                    col_next   = '0;
                    row_next   = '0;
                    value_next = '0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RDWAIT:
            begin
                value_next = mem_rdata;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            col_reg        <= '0;
            row_reg        <= ROW_W'(2);
            scan_reg       <= '0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            attr_reg       <= ATTR_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            scan_reg       <= scan_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
            pend_valid_reg <= pend_valid_next;
            if (psel && penable && pwrite && (paddr[2] == REG_ATTRIBUTE))
            begin
                attr_reg <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg      <= code_next;
        value_reg     <= value_next;
        pend_copy_reg <= pend_copy_next;
        pend_addr_reg <= scan_reg;
    end

    assign row_wide = {{ROW_OUT_W{1'b0}}, row_reg};
    assign col_wide = {{COL_OUT_W{1'b0}}, col_reg};

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign cursor_row = row_wide[ROW_OUT_W-1:0];
    assign cursor_col = col_wide[COL_OUT_W-1:0];
    assign cell_value = value_reg;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_ATTRIBUTE) ? {16'd0, attr_reg} : 32'd0;

endmodule

// ===== sim/text_console_writer_tb.sv =====
`timescale 1ns / 1ps

module text_console_writer_tb
    import tcw_pkg::*;
();

    localparam int COLS          = COLUMNS_DEF;
    localparam int LINES         = ROWS_DEF;
    localparam int TAB_WIDTH     = TAB_SPACES_DEF;
    localparam int CELL_COUNT    = COLS * LINES;
    localparam int PHASE_ITEMS   = 325;
    localparam int DRAIN_CYCLES  = CELL_COUNT + 100;
    localparam int CYCLE_LIMIT   = 20_000_000;
    localparam int MAX_MESSAGES  = 50;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [2:0] ATTR_ADDR   = 3'({REG_ATTRIBUTE, 2'b00});

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic [CELL_W-1:0]    cell_val;
    } cursor_result_t;

    class console_scoreboard;
        logic [CELL_W-1:0]    screen [CELL_COUNT];
        logic [COL_OUT_W-1:0] col;
        logic [ROW_OUT_W-1:0] row;
        logic [CELL_W-1:0]    attr;
        cursor_result_t       expected_q [$];
        int                   fails;
        int                   scrolls;
        int                   wraps;
        int                   clears;

        function new();
            foreach (screen[i]) screen[i] = '0;
            col     = '0;
            row     = 5'd2;
            attr    = ATTR_RESET;
            fails   = 0;
            scrolls = 0;
            wraps   = 0;
            clears  = 0;
        endfunction

        function void load_attr(logic [CELL_W-1:0] value);
            attr = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void settle();
            if (col >= COLS) begin
                col = '0;
                row = row + 1'b1;
                wraps++;
            end
            if (row >= LINES) begin
                for (int i = 0; i < CELL_COUNT - COLS; i++) screen[i] = screen[i + COLS];
                for (int i = CELL_COUNT - COLS; i < CELL_COUNT; i++)
                    screen[i] = attr | CELL_W'(SPACE_CHAR);
                col = '0;
                row = ROW_OUT_W'(LINES - 1);
                scrolls++;
            end
        endfunction

        function void put_cell(logic [7:0] code);
            settle();
            screen[int'(row) * COLS + int'(col)] = attr | CELL_W'(code);
            col = col + 1'b1;
        endfunction

        function void note_input(logic [1:0] m, logic [7:0] c, logic [INDEX_W-1:0] ix);
            cursor_result_t r;
            r.cell_val = '0;
            case (m)
                MODE_PUT: begin
                    settle();
                    if (c == NEWLINE_CHAR) begin
                        col = '0;
                        row = row + 1'b1;
                    end else if (c == TAB_CHAR) begin
                        repeat (TAB_WIDTH) put_cell(SPACE_CHAR);
                    end else begin
                        put_cell(c);
                    end
                end
                MODE_CLEAR: begin
                    foreach (screen[i]) screen[i] = attr | CELL_W'(SPACE_CHAR);
                    col = '0;
                    row = '0;
                    clears++;
                end
                MODE_READ: begin
                    if (ix < CELL_COUNT) r.cell_val = screen[ix];
                end
                default: ;
            endcase
            r.row = row;
            r.col = col;
            expected_q.push_back(r);
        endfunction

        task report(input string msg);
            fails++;
            if (fails <= MAX_MESSAGES) $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_result(input logic [ROW_OUT_W-1:0] r_row, input logic [COL_OUT_W-1:0] r_col,
                          input logic [CELL_W-1:0] r_cell);
            cursor_result_t e;
            if (expected_q.size() == 0) begin
                report("result strobed with no command outstanding");
            end else begin
                e = expected_q.pop_front();
                if (r_row !== e.row)
                    report($sformatf("cursor_row %0d, expected %0d", r_row, e.row));
                if (r_col !== e.col)
                    report($sformatf("cursor_col %0d, expected %0d", r_col, e.col));
                if (r_cell !== e.cell_val)
                    report($sformatf("cell_value %h, expected %h", r_cell, e.cell_val));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    logic [1:0]           mode       = MODE_PUT;
    logic [7:0]           char_code  = '0;
    logic [INDEX_W-1:0]   cell_index = '0;
    logic                 done;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [CELL_W-1:0]    cell_value;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [2:0]           paddr      = '0;
    logic [31:0]          pwdata     = '0;
    logic [31:0]          prdata;
    logic                 pready;

    console_scoreboard sb = new();
    int                items_sent = 0;
    int                mode_count [4] = '{default: 0};
    int                attr_settings = 1;
    int                cycle_count = 0;

    text_console_writer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .char_code  (char_code),
        .cell_index (cell_index),
        .done       (done),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cell_value (cell_value),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_result(cursor_row, cursor_col, cell_value);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped by the cycle limit with %0d results outstanding", sb.pending());
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_item(input logic [1:0] m, input logic [7:0] c,
                             input logic [INDEX_W-1:0] ix, input bit gaps);
        if (gaps && $urandom_range(0, 4) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        mode       <= m;
        char_code  <= c;
        cell_index <= ix;
        start      <= 1'b1;
        do @(posedge clk); while (busy);
        sb.note_input(m, c, ix);
        items_sent++;
        mode_count[m]++;
    endtask

    function automatic logic [INDEX_W-1:0] random_index();
        if ($urandom_range(0, 4) == 0) return INDEX_W'($urandom_range(0, 2 ** INDEX_W - 1));
        return INDEX_W'($urandom_range(0, CELL_COUNT - 1));
    endfunction

    task automatic put_char(input logic [7:0] c, input bit gaps);
        send_item(MODE_PUT, c, INDEX_W'($urandom), gaps);
    endtask

    task automatic read_cell(input logic [INDEX_W-1:0] ix, input bit gaps);
        send_item(MODE_READ, 8'($urandom), ix, gaps);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [CELL_W-1:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ATTR_ADDR;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.load_attr(value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[CELL_W-1:0] !== value)
            sb.report($sformatf("attribute read back as %h, written %h", readback, value));
        attr_settings++;
    endtask

    task automatic type_line(input bit gaps);
        int len;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) len = COLS;
        else if (pick == 1) len = $urandom_range(COLS + 1, 2 * COLS + 10);
        else len = $urandom_range(0, 60);
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) read_cell(random_index(), gaps);
            else if (pick < 10) put_char(TAB_CHAR, gaps);
            else if (pick < 13) put_char(8'($urandom_range(0, 255)), gaps);
            else put_char(8'($urandom_range(32, 126)), gaps);
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) put_char(NEWLINE_CHAR, gaps);
        else if (pick < 85) put_char(TAB_CHAR, gaps);
        if ($urandom_range(0, 39) == 0)
            send_item(MODE_CLEAR, 8'($urandom), INDEX_W'($urandom), gaps);
        if ($urandom_range(0, 29) == 0)
            send_item(MODE_UNUSED, 8'($urandom), INDEX_W'($urandom), gaps);
    endtask

    initial
    begin
        logic [CELL_W-1:0] phase_attr [5];
        int                target;
        bit                gaps;

        phase_attr[0] = 16'h0000;
        phase_attr[1] = 16'hFFFF;
        phase_attr[2] = CELL_W'($urandom);
        phase_attr[3] = CELL_W'($urandom);
        phase_attr[4] = ATTR_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed commands run with the attribute left at its reset value.
        read_cell(INDEX_W'(0), 1'b0);
        read_cell(INDEX_W'(CELL_COUNT - 1), 1'b0);
        read_cell(INDEX_W'(CELL_COUNT), 1'b0);
        read_cell('1, 1'b0);
        send_item(MODE_UNUSED, 8'hFF, '1, 1'b0);
        put_char(8'h00, 1'b0);
        put_char(8'hFF, 1'b0);
        put_char(8'h41, 1'b0);
        put_char(TAB_CHAR, 1'b0);
        read_cell(INDEX_W'(2 * COLS), 1'b0);
        read_cell(INDEX_W'(2 * COLS + 1), 1'b0);
        read_cell(INDEX_W'(2 * COLS + 4), 1'b0);
        put_char(NEWLINE_CHAR, 1'b0);
        put_char(NEWLINE_CHAR, 1'b0);
        send_item(MODE_CLEAR, 8'h00, '0, 1'b0);
        read_cell(INDEX_W'(0), 1'b0);
        read_cell(INDEX_W'(CELL_COUNT - 1), 1'b0);
        put_char(8'h5A, 1'b0);
        read_cell(INDEX_W'(0), 1'b0);
        put_char(NEWLINE_CHAR, 1'b0);

        for (int p = 0; p < 5; p++) begin
            wait_idle();
            write_attribute(phase_attr[p]);
            target = (p + 1) * PHASE_ITEMS;
            while (items_sent < target) begin
                gaps = (p < 4) && ($urandom_range(0, 2) != 0);
                type_line(gaps);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands (%0d put, %0d clear, %0d read, %0d unused) under %0d attributes.",
                 items_sent, mode_count[0], mode_count[1], mode_count[2], mode_count[3],
                 attr_settings);
        $display("The writer went through %0d line wraps, %0d scrolls and %0d clears.",
                 sb.wraps, sb.scrolls, sb.clears);
        if (sb.fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
